>>> design/psrd_pkg.sv
// Shared types, constants and helpers for the per-source rate detector.
package psrd_pkg;

   typedef enum logic [1:0] {
      ALERT_NONE  = 2'd0,
      ALERT_BRUTE = 2'd1,
      ALERT_SCAN  = 2'd2
   } alert_type;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_MS  = 2'd0;
   localparam logic [1:0] CSR_POST_LIMIT = 2'd1;
   localparam logic [1:0] CSR_HIT_LIMIT  = 2'd2;

   localparam logic [31:0] WINDOW_MS_RESET  = 32'd60000;
   localparam logic [7:0]  POST_LIMIT_RESET = 8'd5;
   localparam logic [7:0]  HIT_LIMIT_RESET  = 8'd20;
   localparam logic [7:0]  COUNT_MAX        = 8'hFF;

   typedef struct packed {
      logic [31:0] window_ms;
      logic [7:0]  post_limit;
      logic [7:0]  hit_limit;
   } cfg_type;

   // request token walking down the row of cells
   typedef struct packed {
      logic        vld;
      logic        done;
      logic [31:0] src_ip;
      logic        is_post;
      logic [31:0] now_ms;
      alert_type   alert;
      logic [7:0]  hit_total;
      logic [7:0]  post_total;
   } token_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
   endfunction

endpackage

>>> design/per_source_rate_detector_unit.sv
// Top level of the per-source rate detector: config registers, cell row, response register.
// A request enters a row of NUM_ENTRIES cells, each holding one source entry, and walks one
// cell per cycle unless the row is held behind an uncollected response; the first cell whose
// key matches, or the first free cell (entries fill in order and never free up), counts the
// hit and applies the window and both alert rules. One request is in flight at a time, so a
// new request is accepted only after the last one leaves the row. A request that reaches the
// end of the row unclaimed reports table_full with zero counts. The next request is taken as
// soon as the previous response sits in the output register, even if it has not yet been
// collected.
module per_source_rate_detector_unit
   import psrd_pkg::*;
#(
   parameter int NUM_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_src_ip,
   input  logic        req_is_post,
   input  logic [31:0] req_now_ms,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_alert,
   output logic [7:0]  rsp_hit_total,
   output logic [7:0]  rsp_post_total,
   output logic        rsp_table_full
);

   cfg_type   cfg_ff, cfg_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   alert_type rsp_alert_ff;
   logic [7:0] rsp_hit_total_ff, rsp_post_total_ff;
   logic      rsp_table_full_ff;

   token_type inject;
   token_type chain_tok [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] chain_vld;
   logic      accept, advance, tail_vld, load_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_MS:  cfg_in.window_ms  = csr_wdata;
            CSR_POST_LIMIT: cfg_in.post_limit = csr_wdata[7:0];
            CSR_HIT_LIMIT:  cfg_in.hit_limit  = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms  <= WINDOW_MS_RESET;
         cfg_ff.post_limit <= POST_LIMIT_RESET;
         cfg_ff.hit_limit  <= HIT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign tail_vld  = chain_tok[NUM_ENTRIES-1].vld;
   // hold the row while a finished request waits behind an uncollected response
   assign advance   = !(tail_vld && rsp_valid_ff && !rsp_ready);
   assign load_rsp  = tail_vld && advance;

   always_comb begin
      inject.vld        = accept;
      inject.done       = 1'b0;
      inject.src_ip     = req_src_ip;
      inject.is_post    = req_is_post;
      inject.now_ms     = req_now_ms;
      inject.alert      = ALERT_NONE;
      inject.hit_total  = 8'd0;
      inject.post_total = 8'd0;
   end

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      psrd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cfg     (cfg_ff),
         .tok_in  ((i == 0) ? inject : chain_tok[(i == 0) ? 0 : i-1]),
         .tok_out (chain_tok[i])
      );
      assign chain_vld[i] = chain_tok[i].vld;
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_alert_ff      <= chain_tok[NUM_ENTRIES-1].alert;
         rsp_hit_total_ff  <= chain_tok[NUM_ENTRIES-1].hit_total;
         rsp_post_total_ff <= chain_tok[NUM_ENTRIES-1].post_total;
         rsp_table_full_ff <= !chain_tok[NUM_ENTRIES-1].done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alert      = rsp_alert_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_post_total = rsp_post_total_ff;
   assign rsp_table_full = rsp_table_full_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld))
      else $error("more than one request in the cell row");

   a_busy_tracks_row: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (|chain_vld))
      else $error("busy flag disagrees with the cell row");

   a_full_no_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_table_full_ff |->
         rsp_alert_ff == ALERT_NONE && rsp_hit_total_ff == 8'd0 && rsp_post_total_ff == 8'd0)
      else $error("table_full response carries counts");

   a_scan_reached: assert property (@(posedge clock) disable iff (reset)
      load_rsp && chain_tok[NUM_ENTRIES-1].alert == ALERT_SCAN |->
         chain_tok[NUM_ENTRIES-1].hit_total >= cfg_ff.hit_limit)
      else $error("scan alert below threshold");

endmodule

>>> design/psrd_cell.sv
// One table entry of the rate detector, with the token register to its neighbour.
module psrd_cell
   import psrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  cfg_type   cfg,
   input  token_type tok_in,
   output token_type tok_out
);

   logic        valid_ff, valid_in;
   logic [31:0] key_ff, key_in;
   logic [7:0]  hits_ff, hits_in;
   logic [7:0]  posts_ff, posts_in;
   logic [31:0] wstart_ff, wstart_in;
   token_type   tok_ff, tok_in_nxt;

   logic        hit, claim, take, expire, brute, scan;
   logic [7:0]  base_hits, base_posts, h0, p0, h1, p1;
   logic [31:0] base_wstart, elapsed;

   always_comb begin
      hit   = valid_ff && (key_ff == tok_in.src_ip);
      claim = !valid_ff;
      take  = tok_in.vld && !tok_in.done && (hit || claim);

      // a freshly claimed entry starts with zero counts and window start
      base_hits   = claim ? 8'd0  : hits_ff;
      base_posts  = claim ? 8'd0  : posts_ff;
      base_wstart = claim ? 32'd0 : wstart_ff;

      elapsed = tok_in.now_ms - base_wstart;
      expire  = elapsed > cfg.window_ms;
      h0      = expire ? 8'd0 : base_hits;
      p0      = expire ? 8'd0 : base_posts;
      h1      = sat_inc(h0);
      p1      = tok_in.is_post ? sat_inc(p0) : p0;
      brute   = p1 >= cfg.post_limit;
      scan    = !brute && (h1 >= cfg.hit_limit);

      valid_in  = valid_ff;
      key_in    = key_ff;
      hits_in   = hits_ff;
      posts_in  = posts_ff;
      wstart_in = wstart_ff;
      tok_in_nxt = tok_in;
      if (take) begin
         valid_in  = 1'b1;
         key_in    = tok_in.src_ip;
         wstart_in = expire ? tok_in.now_ms : base_wstart;
         hits_in   = scan ? 8'd0 : h1;
         posts_in  = brute ? 8'd0 : p1;
         tok_in_nxt.done       = 1'b1;
         tok_in_nxt.hit_total  = h1;
         tok_in_nxt.post_total = p1;
         tok_in_nxt.alert      = brute ? ALERT_BRUTE : (scan ? ALERT_SCAN : ALERT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else if (advance) begin
         valid_ff  <= valid_in;
         key_ff    <= key_in;
         hits_ff   <= hits_in;
         posts_ff  <= posts_in;
         wstart_ff <= wstart_in;
         tok_ff    <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> bench/psrd_checker.sv
// Response checker for the per-source rate detector: tracks the source table and compares.
module psrd_checker
   import psrd_pkg::*;
#(
   parameter int NUM_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_src_ip,
   input  logic        req_is_post,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_alert,
   input  logic [7:0]  rsp_hit_total,
   input  logic [7:0]  rsp_post_total,
   input  logic        rsp_table_full,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      alert_type  alert;
      logic [7:0] hit_total;
      logic [7:0] post_total;
      logic       table_full;
   } hit_verdict_type;

   cfg_type         cfg;
   logic            src_used   [NUM_ENTRIES];
   logic [31:0]     src_key    [NUM_ENTRIES];
   logic [7:0]      src_hits   [NUM_ENTRIES];
   logic [7:0]      src_posts  [NUM_ENTRIES];
   logic [31:0]     src_start  [NUM_ENTRIES];
   hit_verdict_type verdict_q[$];
   int              fails = 0;
   int              n_waiting = 0;

   assign fail_count = fails;
   assign pending    = n_waiting;

   function automatic logic [7:0] bump(input logic [7:0] v);
      return (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   // Look the source up, open an entry if needed, then apply window and both rules.
   function automatic hit_verdict_type score_hit(input logic [31:0] ip, input logic post,
                                                 input logic [31:0] now);
      hit_verdict_type v;
      int slot;
      int spare;
      logic [31:0] elapsed;
      v = '0;
      v.alert = ALERT_NONE;
      slot = -1;
      spare = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (src_used[i]) begin
            if (slot < 0 && src_key[i] == ip) slot = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (slot < 0 && spare < 0) begin
         v.table_full = 1'b1;
         return v;
      end
      if (slot < 0) begin
         slot = spare;
         src_used[slot]  = 1'b1;
         src_key[slot]   = ip;
         src_hits[slot]  = 8'd0;
         src_posts[slot] = 8'd0;
         src_start[slot] = 32'd0;
      end
      elapsed = now - src_start[slot];
      if (elapsed > cfg.window_ms) begin
         src_hits[slot]  = 8'd0;
         src_posts[slot] = 8'd0;
         src_start[slot] = now;
      end
      src_hits[slot] = bump(src_hits[slot]);
      if (post) src_posts[slot] = bump(src_posts[slot]);
      v.hit_total  = src_hits[slot];
      v.post_total = src_posts[slot];
      if (src_posts[slot] >= cfg.post_limit) begin
         v.alert = ALERT_BRUTE;
         src_posts[slot] = 8'd0;
      end else if (src_hits[slot] >= cfg.hit_limit) begin
         v.alert = ALERT_SCAN;
         src_hits[slot] = 8'd0;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      hit_verdict_type want;
      if (reset) begin
         cfg.window_ms  = WINDOW_MS_RESET;
         cfg.post_limit = POST_LIMIT_RESET;
         cfg.hit_limit  = HIT_LIMIT_RESET;
         for (int i = 0; i < NUM_ENTRIES; i++) src_used[i] = 1'b0;
         verdict_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW_MS:  cfg.window_ms  = csr_wdata;
               CSR_POST_LIMIT: cfg.post_limit = csr_wdata[7:0];
               CSR_HIT_LIMIT:  cfg.hit_limit  = csr_wdata[7:0];
               default: ;
            endcase
         end
         // retire the oldest verdict before scoring a new request
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected response: alert %0d hits %0d posts %0d full %0b",
                           rsp_alert, rsp_hit_total, rsp_post_total, rsp_table_full);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_alert !== want.alert || rsp_hit_total !== want.hit_total ||
                   rsp_post_total !== want.post_total ||
                   rsp_table_full !== want.table_full) begin
                  fails++;
                  if (fails <= 10)
                     $display({"response mismatch: expected alert %0d hits %0d posts %0d ",
                               "full %0b, got alert %0d hits %0d posts %0d full %0b"},
                              want.alert, want.hit_total, want.post_total, want.table_full,
                              rsp_alert, rsp_hit_total, rsp_post_total, rsp_table_full);
               end
            end
         end
         if (req_valid && req_ready)
            verdict_q.push_back(score_hit(req_src_ip, req_is_post, req_now_ms));
      end
      n_waiting = verdict_q.size();
   end

endmodule

>>> bench/tb.sv
// Testbench top for the per-source rate detector: clock, reset, requests, settings and verdict.
module tb;
   import psrd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = 32;
   localparam int POOL_SIZE   = 40;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_HOLD
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_src_ip = 32'd0;
   logic        req_is_post = 1'b0;
   logic [31:0] req_now_ms = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_alert;
   logic [7:0]  rsp_hit_total;
   logic [7:0]  rsp_post_total;
   logic        rsp_table_full;

   int          fail_count;
   int          pending;

   ready_mode_type ready_mode = READY_ALWAYS;
   int          ready_left = 0;
   int          burst_left = 0;
   logic [31:0] src_pool [POOL_SIZE];
   logic [31:0] cur_ms = 32'd0;
   int unsigned step_max = 1;
   int          post_pct = 50;
   logic [31:0] win;
   logic [7:0]  brute;
   logic [7:0]  scan;

   always #2 clock = ~clock;

   per_source_rate_detector_unit #(.NUM_ENTRIES(NUM_ENTRIES)) uut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_src_ip(req_src_ip),
      .req_is_post(req_is_post), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_alert(rsp_alert),
      .rsp_hit_total(rsp_hit_total), .rsp_post_total(rsp_post_total),
      .rsp_table_full(rsp_table_full)
   );

   psrd_checker #(.NUM_ENTRIES(NUM_ENTRIES)) rate_check (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_src_ip(req_src_ip),
      .req_is_post(req_is_post), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_alert(rsp_alert),
      .rsp_hit_total(rsp_hit_total), .rsp_post_total(rsp_post_total),
      .rsp_table_full(rsp_table_full),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver: switch between stall patterns every stretch
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(16, 100);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= (ready_left % 5 == 0);
         default:      rsp_ready <= 1'b0;
      endcase
   end

   // send one request, opening a new burst after a random gap when the last one ran out
   task automatic issue_hit(input logic [31:0] ip, input logic post, input logic [31:0] now);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_src_ip  <= ip;
      req_is_post <= post;
      req_now_ms  <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every outstanding request has been answered
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      // let the count take in the request accepted at this edge
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] w, input logic [7:0] b, input logic [7:0] s);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(CSR_WINDOW_MS, w);
      write_reg(CSR_POST_LIMIT, {junk[31:8], b});
      junk = $urandom;
      write_reg(CSR_HIT_LIMIT, {junk[31:8], s});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_hit();
      logic [31:0] ip;
      logic        post;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) ip = $urandom;
      else if (pick < 35) ip = src_pool[$urandom_range(0, POOL_SIZE - 1)];
      else ip = src_pool[$urandom_range(0, 5)];
      post = ($urandom_range(0, 99) < post_pct);
      pick = $urandom_range(0, 99);
      if (pick < 75) cur_ms = cur_ms + $urandom_range(0, step_max);
      else if (pick >= 88 && pick < 95) cur_ms = cur_ms + $urandom;
      else if (pick >= 95) cur_ms = $urandom;
      issue_hit(ip, post, cur_ms);
   endtask

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      src_pool[0] = 32'h0;
      for (int i = 1; i < POOL_SIZE; i++) src_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: new sources, wrapped elapsed time, brute force, window edge
      issue_hit(32'h0, 1'b0, 32'h0);
      issue_hit(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      issue_hit(32'hFFFF_FFFF, 1'b1, 32'd5);
      issue_hit(32'hFFFF_FFFF, 1'b1, 32'd6);
      issue_hit(32'hFFFF_FFFF, 1'b1, 32'd7);
      issue_hit(32'hFFFF_FFFF, 1'b1, 32'd8);
      issue_hit(32'h0, 1'b1, 32'd60000);
      issue_hit(32'h0, 1'b0, 32'd60001);
      drain();

      // zero window and zero thresholds
      load_settings(32'd0, 8'd0, 8'd0);
      issue_hit(32'h0, 1'b0, 32'd60001);
      issue_hit(32'h0, 1'b1, 32'd60002);
      drain();

      // widest window, brute rule out of reach, scan at two
      load_settings(32'hFFFF_FFFF, 8'hFF, 8'd2);
      issue_hit(32'h8000_0001, 1'b0, 32'h0);
      issue_hit(32'h8000_0001, 1'b1, 32'hFFFF_FFFF);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin win = $urandom_range(1, 40); brute = 8'd3; scan = 8'hFF; end
            1: begin win = 32'd1; brute = 8'd1; scan = 8'd4; end
            2: begin win = 32'hFFFF_FFFF; brute = 8'hFF; scan = 8'd1; end
            3: begin
               win = $urandom;
               brute = 8'($urandom_range(1, 10));
               scan = 8'($urandom_range(1, 30));
            end
            4: begin win = $urandom_range(1, 200); brute = 8'd2; scan = 8'd12; end
            5: begin
               win = $urandom_range(1, 40);
               brute = 8'($urandom_range(1, 255));
               scan = 8'($urandom_range(1, 255));
            end
            6: begin win = $urandom_range(20, 2000); brute = 8'd6; scan = 8'd7; end
            default: begin
               win = WINDOW_MS_RESET; brute = POST_LIMIT_RESET; scan = HIT_LIMIT_RESET;
            end
         endcase
         if (phase == 3) write_reg(CSR_SPARE, $urandom);
         load_settings(win, brute, scan);
         step_max = (win < 32'd5000) ? win * 2 + 1 : 800;
         post_pct = $urandom_range(10, 90);
         repeat (170) random_hit();
         drain();
      end

      // POST-only flood: brute rule fires every time, hit count climbs to saturation
      load_settings(32'hFFFF_FFFF, 8'd1, 8'hFF);
      repeat (280) issue_hit(src_pool[0], 1'b1, $urandom);
      drain();

      repeat (NUM_ENTRIES + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
